/* rtl/tracker_pattern_decoder_defines.svh */
// assertion macros for the tracker pattern decoder checker
// expects clk and rst_n in the scope where a macro is used
`ifndef TRACKER_PATTERN_DECODER_DEFINES_SVH
`define TRACKER_PATTERN_DECODER_DEFINES_SVH

// same-cycle implication, quiet while reset is held
`define TPD_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("tpd check failed");

// next-cycle implication, quiet while reset is held
`define TPD_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("tpd check failed");

`endif

/* rtl/tpd_pkg.sv */
// shared types and constants of the tracker pattern decoder
// used by the controller, the datapath and the top level
package tpd_pkg;

  localparam int BYTE_W     = 8;
  localparam int CHAN_W     = 5;
  localparam int NOTE_W     = 7;
  localparam int INSTR_W    = 16;
  localparam int VOL_W      = 8;
  localparam int EFF_W      = 8;
  localparam int PARAM_W    = 8;
  localparam int ROW_W      = 16;
  localparam int CFG_W      = 6;
  localparam int HDR_W      = 6;
  localparam int CELL_W     = NOTE_W + INSTR_W + VOL_W + EFF_W + PARAM_W;
  localparam int OUT_RAW_W  = CHAN_W + 1 + CELL_W + ROW_W;
  localparam int OUT_DATA_W = ((OUT_RAW_W + 7) / 8) * 8;
  localparam int OUT_PAD_W  = OUT_DATA_W - OUT_RAW_W;

  // cell layout: note, instrument, volume, effect, parameter from bit 0 up
  localparam int SH_NOTE  = 0;
  localparam int SH_INSTR = SH_NOTE + NOTE_W;
  localparam int SH_VOL   = SH_INSTR + INSTR_W;
  localparam int SH_EFF   = SH_VOL + VOL_W;
  localparam int SH_PARAM = SH_EFF + EFF_W;

  localparam logic [CFG_W-1:0]  CFG_RESET = 6'd8;
  localparam logic [BYTE_W-1:0] CHAN_MASK = 8'h1f;
  localparam logic [BYTE_W-1:0] FLW_NOTE  = 8'h20;
  localparam logic [BYTE_W-1:0] FLW_VOL   = 8'h40;
  localparam logic [BYTE_W-1:0] FLW_EFF   = 8'h80;
  localparam logic [BYTE_W-1:0] NOTE_MASK = 8'h7f;

  typedef enum logic [12:0] {
    ST_HEADER     = 13'b0000000000001,
    ST_ROWS_LO    = 13'b0000000000010,
    ST_ROWS_HI    = 13'b0000000000100,
    ST_FOLLOW     = 13'b0000000001000,
    ST_NOTE       = 13'b0000000010000,
    ST_INSTR_LO   = 13'b0000000100000,
    ST_INSTR_WIDE = 13'b0000001000000,
    ST_INSTR_HI   = 13'b0000010000000,
    ST_VOLUME     = 13'b0000100000000,
    ST_EFFECT     = 13'b0001000000000,
    ST_PARAM      = 13'b0010000000000,
    ST_EMIT       = 13'b0100000000000,
    ST_DONE       = 13'b1000000000000
  } ctrl_state_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_HEADER,
    OP_ROWS_LO,
    OP_ROWS_HI,
    OP_FOLLOW,
    OP_NOTE,
    OP_INSTR_LO,
    OP_INSTR_HI,
    OP_VOLUME,
    OP_EFFECT,
    OP_PARAM
  } byte_op_t;

  typedef struct packed {
    byte_op_t op;
    logic     commit;
    logic     emit_start;
    logic     emit_step;
  } tpd_cmd_t;

  typedef struct packed {
    logic hdr_last;
    logic byte_zero;
    logic byte_note;
    logic byte_vol;
    logic byte_eff;
    logic note_wide;
    logic rows_zero;
    logic flag_vol;
    logic flag_eff;
    logic emit_last;
    logic row_last;
    logic out_free;
  } tpd_status_t;

endpackage

/* rtl/tpd_ctrl.sv */
// parse and emit controller of the tracker pattern decoder
// depends on tpd_pkg for the state, command and status types
module tpd_ctrl #(
  parameter int HEADER_WORDS = 16
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_tvalid,
  output logic               in_tready,
  input  tpd_pkg::tpd_status_t sts,
  output tpd_pkg::tpd_cmd_t  cmd
);
  import tpd_pkg::*;

  ctrl_state_t state_r, state_nxt;
  logic        take;

  assign in_tready = (state_r != ST_EMIT);
  assign take      = in_tvalid & in_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= (HEADER_WORDS == 0) ? ST_ROWS_LO : ST_HEADER;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt      = state_r;
    cmd.op         = OP_NONE;
    cmd.commit     = 1'b0;
    cmd.emit_start = 1'b0;
    cmd.emit_step  = 1'b0;
    case (state_r)
      ST_HEADER: begin
        if (take) begin
          cmd.op = OP_HEADER;
          if (sts.hdr_last) state_nxt = ST_ROWS_LO;
        end
      end
      ST_ROWS_LO: begin
        if (take) begin
          cmd.op    = OP_ROWS_LO;
          state_nxt = ST_ROWS_HI;
        end
      end
      ST_ROWS_HI: begin
        if (take) begin
          cmd.op    = OP_ROWS_HI;
          state_nxt = sts.rows_zero ? ST_DONE : ST_FOLLOW;
        end
      end
      ST_FOLLOW: begin
        if (take) begin
          if (sts.byte_zero) begin
            cmd.emit_start = 1'b1;
            state_nxt      = ST_EMIT;
          end else begin
            cmd.op = OP_FOLLOW;
            if (sts.byte_note) state_nxt = ST_NOTE;
            else if (sts.byte_vol) state_nxt = ST_VOLUME;
            else if (sts.byte_eff) state_nxt = ST_EFFECT;
            else cmd.commit = 1'b1;
          end
        end
      end
      ST_NOTE: begin
        if (take) begin
          cmd.op    = OP_NOTE;
          state_nxt = sts.note_wide ? ST_INSTR_WIDE : ST_INSTR_LO;
        end
      end
      ST_INSTR_WIDE: begin
        if (take) begin
          cmd.op    = OP_INSTR_LO;
          state_nxt = ST_INSTR_HI;
        end
      end
      ST_INSTR_LO, ST_INSTR_HI: begin
        if (take) begin
          cmd.op = (state_r == ST_INSTR_HI) ? OP_INSTR_HI : OP_INSTR_LO;
          if (sts.flag_vol) state_nxt = ST_VOLUME;
          else if (sts.flag_eff) state_nxt = ST_EFFECT;
          else begin
            cmd.commit = 1'b1;
            state_nxt  = ST_FOLLOW;
          end
        end
      end
      ST_VOLUME: begin
        if (take) begin
          cmd.op = OP_VOLUME;
          if (sts.flag_eff) state_nxt = ST_EFFECT;
          else begin
            cmd.commit = 1'b1;
            state_nxt  = ST_FOLLOW;
          end
        end
      end
      ST_EFFECT: begin
        if (take) begin
          cmd.op    = OP_EFFECT;
          state_nxt = ST_PARAM;
        end
      end
      ST_PARAM: begin
        if (take) begin
          cmd.op     = OP_PARAM;
          cmd.commit = 1'b1;
          state_nxt  = ST_FOLLOW;
        end
      end
      ST_EMIT: begin
        if (sts.out_free) begin
          cmd.emit_step = 1'b1;
          if (sts.emit_last) state_nxt = sts.row_last ? ST_DONE : ST_FOLLOW;
        end
      end
      ST_DONE: begin
        // trailing bytes are taken and dropped
      end
      default: begin
        state_nxt = ST_DONE;
      end
    endcase
  end

endmodule

/* rtl/tpd_datapath.sv */
// datapath of the tracker pattern decoder: counters, entry assembly,
// row cell store and output register; depends on tpd_pkg
module tpd_datapath #(
  parameter int MAX_CHANNELS = 32,
  parameter int HEADER_WORDS = 16
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic [tpd_pkg::BYTE_W-1:0]      in_byte,
  input  logic                            cfg_wr_en,
  input  logic [tpd_pkg::CFG_W-1:0]       cfg_wr_data,
  input  tpd_pkg::tpd_cmd_t               cmd,
  output tpd_pkg::tpd_status_t            sts,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [tpd_pkg::OUT_DATA_W-1:0]  out_tdata,
  output logic                            out_tlast,
  output logic                            out_tuser
);
  import tpd_pkg::*;

  localparam int CIDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int CNT_W  = $clog2(MAX_CHANNELS + 1);
  localparam int HDR_LEN = 2 * HEADER_WORDS;

  logic [CFG_W-1:0]      cfg_r;
  logic [HDR_W-1:0]      hdr_cnt_r, hdr_cnt_nxt;
  logic [HDR_W:0]        hdr_inc;
  logic [ROW_W-1:0]      rows_total_r, rows_total_nxt;
  logic [ROW_W-1:0]      row_cnt_r, row_cnt_nxt;
  logic                  flag_vol_r, flag_eff_r;
  logic [CHAN_W-1:0]     chan_r, chan_nxt;
  logic [CELL_W-1:0]     fields_r, fields_nxt;
  logic [MAX_CHANNELS-1:0] present_r;
  logic [CELL_W-1:0]     cell_store_r [MAX_CHANNELS];
  logic [CNT_W-1:0]      emit_cnt_r, emit_idx_r;
  logic [CNT_W-1:0]      emit_cnt;
  logic                  cell_set;
  logic                  store_ok;
  logic                  out_valid_r;
  logic [OUT_DATA_W-1:0] out_data_r;
  logic                  out_last_r, out_done_r;

  assign hdr_inc  = {1'b0, hdr_cnt_r} + 1'b1;
  assign store_ok = ({1'b0, chan_nxt} < (CHAN_W + 1)'(MAX_CHANNELS));

  // status toward the controller
  assign sts.hdr_last  = (hdr_inc >= (HDR_W + 1)'(HDR_LEN)) || (hdr_inc[HDR_W-1:0] == '0);
  assign sts.byte_zero = (in_byte == '0);
  assign sts.byte_note = |(in_byte & FLW_NOTE);
  assign sts.byte_vol  = |(in_byte & FLW_VOL);
  assign sts.byte_eff  = |(in_byte & FLW_EFF);
  assign sts.note_wide = in_byte[BYTE_W-1];
  assign sts.rows_zero = (in_byte == '0) && (rows_total_r[BYTE_W-1:0] == '0);
  assign sts.flag_vol  = flag_vol_r;
  assign sts.flag_eff  = flag_eff_r;
  assign sts.emit_last = ((emit_idx_r + 1'b1) == emit_cnt_r);
  assign sts.row_last  = (({1'b0, row_cnt_r} + 1'b1) == {1'b0, rows_total_r});
  assign sts.out_free  = !out_valid_r || out_tready;

  // channel count sampled at row end, zero taken as one, capped at the store
  always_comb begin
    if (cfg_r == '0) emit_cnt = CNT_W'(1);
    else if ({1'b0, cfg_r} > (CFG_W + 1)'(MAX_CHANNELS)) emit_cnt = CNT_W'(MAX_CHANNELS);
    else emit_cnt = CNT_W'(cfg_r);
  end

  always_comb begin
    hdr_cnt_nxt    = hdr_cnt_r;
    rows_total_nxt = rows_total_r;
    row_cnt_nxt    = row_cnt_r;
    chan_nxt       = chan_r;
    fields_nxt     = fields_r;
    case (cmd.op)
      OP_HEADER:   hdr_cnt_nxt = sts.hdr_last ? '0 : hdr_inc[HDR_W-1:0];
      OP_ROWS_LO:  rows_total_nxt = {{(ROW_W - BYTE_W){1'b0}}, in_byte};
      OP_ROWS_HI: begin
        rows_total_nxt = {in_byte, rows_total_r[BYTE_W-1:0]};
        row_cnt_nxt    = '0;
      end
      OP_FOLLOW: begin
        chan_nxt   = CHAN_W'(in_byte & CHAN_MASK);
        fields_nxt = '0;
      end
      OP_NOTE:     fields_nxt[SH_NOTE +: NOTE_W] = NOTE_W'(in_byte & NOTE_MASK);
      OP_INSTR_LO: fields_nxt[SH_INSTR +: BYTE_W] = in_byte;
      OP_INSTR_HI: fields_nxt[SH_INSTR + BYTE_W +: BYTE_W] = in_byte;
      OP_VOLUME:   fields_nxt[SH_VOL +: VOL_W] = in_byte;
      OP_EFFECT:   fields_nxt[SH_EFF +: EFF_W] = in_byte;
      OP_PARAM:    fields_nxt[SH_PARAM +: PARAM_W] = in_byte;
      default: begin
      end
    endcase
    if (cmd.emit_step && sts.emit_last) row_cnt_nxt = row_cnt_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r        <= CFG_RESET;
      hdr_cnt_r    <= '0;
      rows_total_r <= '0;
      row_cnt_r    <= '0;
      chan_r       <= '0;
      fields_r     <= '0;
      flag_vol_r   <= 1'b0;
      flag_eff_r   <= 1'b0;
      present_r    <= '0;
      emit_cnt_r   <= CNT_W'(1);
      emit_idx_r   <= '0;
    end else begin
      if (cfg_wr_en) cfg_r <= cfg_wr_data;
      hdr_cnt_r    <= hdr_cnt_nxt;
      rows_total_r <= rows_total_nxt;
      row_cnt_r    <= row_cnt_nxt;
      chan_r       <= chan_nxt;
      fields_r     <= fields_nxt;
      if (cmd.op == OP_FOLLOW) begin
        flag_vol_r <= sts.byte_vol;
        flag_eff_r <= sts.byte_eff;
      end
      if (cmd.emit_start) begin
        emit_cnt_r <= emit_cnt;
        emit_idx_r <= '0;
      end else if (cmd.emit_step) begin
        emit_idx_r <= emit_idx_r + 1'b1;
      end
      // row store empties on a new pattern and after each emitted row
      if ((cmd.op == OP_ROWS_HI) || (cmd.emit_step && sts.emit_last)) begin
        present_r <= '0;
      end else if (cmd.commit && store_ok) begin
        present_r[chan_nxt[CIDX_W-1:0]] <= 1'b1;
      end
    end
  end

  // entries read as zero until their present bit is set
  always_ff @(posedge clk) begin
    if (cmd.commit && store_ok) cell_store_r[chan_nxt[CIDX_W-1:0]] <= fields_nxt;
  end

  assign cell_set = present_r[emit_idx_r[CIDX_W-1:0]];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit_step || (out_valid_r && !out_tready);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit_step) begin
      out_data_r <= {{OUT_PAD_W{1'b0}}, row_cnt_r,
                     cell_set ? cell_store_r[emit_idx_r[CIDX_W-1:0]] : {CELL_W{1'b0}},
                     cell_set, CHAN_W'(emit_idx_r)};
      out_last_r <= sts.emit_last;
      out_done_r <= sts.emit_last && sts.row_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_done_r;

endmodule

/* rtl/tracker_pattern_decoder.sv */
// Tracker pattern decoder, top level.
// Input: one pattern byte per request on in_* (header words, 16-bit
// little-endian row count, then follow-byte entries, a zero byte ending
// each row). Output: one channel cell per request on out_*, channel
// order 0 .. channel_count-1, tlast on the row's final cell, tuser on the
// final cell of the pattern.
// in_tready is high in every state but the emit pass. A row-ending byte
// starts an emit pass of channel_count cells (1..32), one cell a cycle
// through a single output register; in_tready is low for the pass. That
// byte puts the controller in its emit state, which loads the first cell.
// A stalled receiver holds the cell in the output register and stops the
// pass; bytes are taken again once the last cell is loaded.
// Reset: synchronous rst_n clears the parser, counters, row store present
// bits and sets channel_count to 8; no clearing pass is needed. The user
// writes channel_count via cfg_wr_en/cfg_wr_data while idle, unchecked.
module tracker_pattern_decoder #(
  parameter int MAX_CHANNELS = 32,
  parameter int HEADER_WORDS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // byte_in
  input  logic [tpd_pkg::BYTE_W-1:0]     in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // cell_channel, cell_set, note_value, instrument_value, volume_value,
  // effect_value, effect_param, row_index, zero pad
  output logic [tpd_pkg::OUT_DATA_W-1:0] out_tdata,
  // last_in_row
  output logic                           out_tlast,
  // pattern_done
  output logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [tpd_pkg::CFG_W-1:0]      cfg_wr_data
);
  import tpd_pkg::*;

  tpd_cmd_t    cmd;
  tpd_status_t sts;

  tpd_ctrl #(
    .HEADER_WORDS(HEADER_WORDS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_tvalid(in_tvalid),
    .in_tready(in_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  tpd_datapath #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .HEADER_WORDS(HEADER_WORDS)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_byte    (in_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .cmd        (cmd),
    .sts        (sts),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser)
  );

endmodule

/* rtl/tpd_checker.sv */
// port-level checks of the tracker pattern decoder, bound to the top level
// depends on tpd_pkg and tracker_pattern_decoder_defines.svh
`include "tracker_pattern_decoder_defines.svh"

module tpd_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_tready,
  input logic                           out_tvalid,
  input logic                           out_tready,
  input logic [tpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input logic                           out_tlast,
  input logic                           out_tuser
);
  import tpd_pkg::*;

  // pattern end only on a row's final cell
  `TPD_ASSERT_NOW(a_done_on_last, out_tvalid && out_tuser, out_tlast)
  // a new cell only appears during an emit pass, never while bytes are taken
  `TPD_ASSERT_NOW(a_load_in_pass, out_tvalid && !$past(out_tvalid), !$past(in_tready))
  // more cells of the row still to come keep input closed
  `TPD_ASSERT_NOW(a_pass_blocks_in, out_tvalid && !out_tlast, !in_tready)
  // stalled request holds
  `TPD_ASSERT_NEXT(a_stall_holds, out_tvalid && !out_tready,
                   out_tvalid && $stable(out_tdata) && $stable(out_tlast))

endmodule

bind tracker_pattern_decoder tpd_checker u_tpd_checker (.*);

/* verif/tpd_cell_checker.sv */
// cell checker for the tracker pattern decoder: watches the byte, cell and config ports,
// decodes the pattern bytes on its own and compares every emitted cell field by field
// depends on tpd_pkg for widths, flag masks and the parser state names
module tpd_cell_checker #(
  parameter int MAX_CHANNELS = 32,
  parameter int HEADER_WORDS = 16
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  input  logic                           in_tready,
  input  logic [tpd_pkg::BYTE_W-1:0]     in_tdata,
  input  logic                           out_tvalid,
  input  logic                           out_tready,
  input  logic [tpd_pkg::OUT_DATA_W-1:0] out_tdata,
  input  logic                           out_tlast,
  input  logic                           out_tuser,
  input  logic                           cfg_wr_en,
  input  logic [tpd_pkg::CFG_W-1:0]      cfg_wr_data,
  output int                             mismatch_count,
  output int                             cells_pending,
  output int                             cells_checked
);
  import tpd_pkg::*;

  localparam int CELL_LSB = CHAN_W + 1;
  localparam int ROW_LSB  = CELL_LSB + CELL_W;
  localparam int STORE_N  = 1 << CHAN_W;

  typedef struct packed {
    logic [PARAM_W-1:0] param;
    logic [EFF_W-1:0]   eff;
    logic [VOL_W-1:0]   vol;
    logic [INSTR_W-1:0] instr;
    logic [NOTE_W-1:0]  note;
  } cell_t;

  typedef struct {
    logic [CHAN_W-1:0] chan;
    logic              set;
    cell_t             vals;
    logic [ROW_W-1:0]  row;
    logic              last;
    logic              done;
  } row_cell_t;

  row_cell_t cells_due[$];

  ctrl_state_t       phase;
  logic [HDR_W-1:0]  hdr_cnt;
  logic [ROW_W-1:0]  rows_total;
  logic [ROW_W-1:0]  row_ctr;
  logic [CFG_W-1:0]  chan_count;
  logic              want_vol;
  logic              want_eff;
  logic [CHAN_W-1:0] entry_chan;
  cell_t             entry;
  logic              chan_used [STORE_N];
  cell_t             chan_cell [STORE_N];

  task automatic clear_row_store();
    for (int i = 0; i < STORE_N; i++) begin
      chan_used[i] = 1'b0;
      chan_cell[i] = '0;
    end
  endtask

  // volume and effect groups follow the note group; the entry lands when none is left
  task automatic next_entry_field();
    if (want_vol) begin
      want_vol = 1'b0;
      phase = ST_VOLUME;
    end else if (want_eff) begin
      want_eff = 1'b0;
      phase = ST_EFFECT;
    end else begin
      if (entry_chan < MAX_CHANNELS) begin
        chan_used[entry_chan] = 1'b1;
        chan_cell[entry_chan] = entry;
      end
      phase = ST_FOLLOW;
    end
  endtask

  task automatic emit_row();
    int n;
    row_cell_t c;
    n = chan_count;
    if (n == 0) n = 1;
    if (n > MAX_CHANNELS) n = MAX_CHANNELS;
    for (int i = 0; i < n; i++) begin
      c.chan = CHAN_W'(i);
      c.set  = chan_used[i];
      c.vals = chan_cell[i];
      c.row  = row_ctr;
      c.last = (i == n - 1);
      c.done = c.last && (row_ctr + ROW_W'(1) == rows_total);
      cells_due.push_back(c);
    end
    clear_row_store();
    row_ctr = row_ctr + ROW_W'(1);
    if (row_ctr == rows_total) phase = ST_DONE;
  endtask

  task automatic parse_pattern_byte(input logic [BYTE_W-1:0] b);
    case (phase)
      ST_HEADER: begin
        hdr_cnt = hdr_cnt + HDR_W'(1);
        if (hdr_cnt >= 2 * HEADER_WORDS || hdr_cnt == 0) begin
          hdr_cnt = '0;
          phase = ST_ROWS_LO;
        end
      end
      ST_ROWS_LO: begin
        rows_total = {8'h00, b};
        phase = ST_ROWS_HI;
      end
      ST_ROWS_HI: begin
        rows_total[15:8] = b;
        row_ctr = '0;
        clear_row_store();
        phase = (rows_total == 0) ? ST_DONE : ST_FOLLOW;
      end
      ST_FOLLOW: begin
        if (b == 0) begin
          emit_row();
        end else begin
          entry_chan = CHAN_W'(b & CHAN_MASK);
          entry = '0;
          want_vol = (b & FLW_VOL) != 0;
          want_eff = (b & FLW_EFF) != 0;
          if ((b & FLW_NOTE) != 0) phase = ST_NOTE;
          else next_entry_field();
        end
      end
      ST_NOTE: begin
        entry.note = NOTE_W'(b & NOTE_MASK);
        // note bit 7 announces a high instrument byte
        phase = b[7] ? ST_INSTR_WIDE : ST_INSTR_LO;
      end
      ST_INSTR_LO: begin
        entry.instr[7:0] = b;
        next_entry_field();
      end
      ST_INSTR_WIDE: begin
        entry.instr[7:0] = b;
        phase = ST_INSTR_HI;
      end
      ST_INSTR_HI: begin
        entry.instr[15:8] = b;
        next_entry_field();
      end
      ST_VOLUME: begin
        entry.vol = b;
        next_entry_field();
      end
      ST_EFFECT: begin
        entry.eff = b;
        phase = ST_PARAM;
      end
      ST_PARAM: begin
        entry.param = b;
        next_entry_field();
      end
      default: begin
        phase = ST_DONE;
      end
    endcase
  endtask

  function automatic void check_field(string label, int want, int got);
    if (want != got) begin
      if (mismatch_count < 40) begin
        $display("%0t: cell %s mismatch, expected %0h, got %0h", $time, label, want, got);
      end
      mismatch_count++;
    end
  endfunction

  always @(posedge clk) begin : cell_monitor
    row_cell_t want;
    cell_t     got;
    if (!rst_n) begin
      phase = (HEADER_WORDS == 0) ? ST_ROWS_LO : ST_HEADER;
      hdr_cnt = '0;
      rows_total = '0;
      row_ctr = '0;
      chan_count = CFG_RESET;
      want_vol = 1'b0;
      want_eff = 1'b0;
      entry_chan = '0;
      entry = '0;
      clear_row_store();
      cells_due.delete();
      mismatch_count = 0;
      cells_checked = 0;
    end else begin
      if (out_tvalid && out_tready) begin
        if (cells_due.size() == 0) begin
          $display("%0t: unexpected cell, expected none, got %0h", $time, out_tdata);
          mismatch_count++;
        end else begin
          want = cells_due.pop_front();
          got = out_tdata[CELL_LSB +: CELL_W];
          check_field("channel", want.chan, out_tdata[0 +: CHAN_W]);
          check_field("set", want.set, out_tdata[CHAN_W]);
          check_field("note", want.vals.note, got.note);
          check_field("instrument", want.vals.instr, got.instr);
          check_field("volume", want.vals.vol, got.vol);
          check_field("effect", want.vals.eff, got.eff);
          check_field("param", want.vals.param, got.param);
          check_field("row", want.row, out_tdata[ROW_LSB +: ROW_W]);
          check_field("pad", 0, out_tdata[OUT_DATA_W-1 -: OUT_PAD_W]);
          check_field("tlast", want.last, out_tlast);
          check_field("tuser", want.done, out_tuser);
          cells_checked++;
        end
      end
      if (cfg_wr_en) chan_count = cfg_wr_data;
      if (in_tvalid && in_tready) parse_pattern_byte(in_tdata);
    end
    cells_pending <= cells_due.size();
  end

endmodule

/* verif/tb_tracker_pattern_decoder.sv */
// testbench top for the tracker pattern decoder: feeds one pattern (header, row count,
// directed rows, random rows, trailing bytes) with bursty requests and a stalling receiver
// depends on tpd_pkg, tracker_pattern_decoder and tpd_cell_checker
module tb_tracker_pattern_decoder;
  import tpd_pkg::*;

  localparam int MAX_CHANNELS = 32;
  localparam int HEADER_WORDS = 16;

  // every entry kind, extreme bytes, an empty entry and an overwrite, then an empty row
  localparam logic [BYTE_W-1:0] SETUP_ROWS [22] = '{
    FLW_NOTE | FLW_VOL | FLW_EFF | 8'd31, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff, 8'hff,
    FLW_NOTE | 8'd1, 8'h00, 8'h00,
    8'd3,
    FLW_VOL | 8'd2, 8'h80,
    FLW_EFF | 8'd4, 8'h01, 8'h7f,
    FLW_NOTE | 8'd1, 8'h85, 8'h12, 8'h34,
    8'h00,
    8'h00
  };
  localparam logic [CFG_W-1:0] COUNT_STEPS [5] = '{6'd1, 6'd0, 6'd63, 6'd8, 6'd33};

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [BYTE_W-1:0]     in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_DATA_W-1:0] out_tdata;
  logic                  out_tlast;
  logic                  out_tuser;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_W-1:0]      cfg_wr_data = '0;

  int mismatch_count;
  int cells_pending;
  int cells_checked;

  int               burst_left = 0;
  int               bytes_sent = 0;
  int               count_writes = 0;
  logic [CFG_W-1:0] chan_setting = CFG_RESET;

  logic [1:0] rx_mode = '0;
  logic [5:0] rx_epoch = '0;
  int         rx_hold = 0;

  always #5 clk = ~clk;

  tracker_pattern_decoder #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .HEADER_WORDS(HEADER_WORDS)
  ) u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  tpd_cell_checker #(
    .MAX_CHANNELS(MAX_CHANNELS),
    .HEADER_WORDS(HEADER_WORDS)
  ) u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_tvalid     (in_tvalid),
    .in_tready     (in_tready),
    .in_tdata      (in_tdata),
    .out_tvalid    (out_tvalid),
    .out_tready    (out_tready),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast),
    .out_tuser     (out_tuser),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .mismatch_count(mismatch_count),
    .cells_pending (cells_pending),
    .cells_checked (cells_checked)
  );

  // receiver: the mode is redrawn each time rx_epoch wraps, among always ready, random and long stalls
  always @(posedge clk) begin
    rx_epoch <= rx_epoch + 6'd1;
    if (rx_epoch == 0) rx_mode <= 2'($urandom_range(0, 2));
    if (rx_hold != 0) begin
      rx_hold <= rx_hold - 1;
    end else begin
      case (rx_mode)
        2'd0: out_tready <= 1'b1;
        2'd1: out_tready <= ($urandom_range(0, 2) != 0);
        default: begin
          out_tready <= ~out_tready;
          rx_hold <= $urandom_range(0, 6);
        end
      endcase
    end
  end

  // one byte request; bursts of random length with idle gaps in between
  task automatic push_byte(input logic [BYTE_W-1:0] b);
    if (burst_left == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk);
      burst_left = ($urandom_range(0, 3) == 0) ? 60 : $urandom_range(1, 12);
    end
    burst_left--;
    in_tvalid <= 1'b1;
    in_tdata <= b;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    bytes_sent++;
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cells_pending != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_channel_count(input logic [CFG_W-1:0] value);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    chan_setting = value;
    count_writes++;
  endtask

  task automatic send_random_row();
    int               n_entries;
    int               active;
    logic [CHAN_W-1:0] chan;
    logic [BYTE_W-1:0] follow;
    logic [BYTE_W-1:0] note;
    n_entries = $urandom_range(0, 3);
    active = (chan_setting == 0) ? 1 :
             (chan_setting > MAX_CHANNELS) ? MAX_CHANNELS : int'(chan_setting);
    repeat (n_entries) begin
      // mostly channels that get emitted, some that are stored only
      chan = ($urandom_range(0, 4) != 0) ? CHAN_W'($urandom_range(0, active - 1))
                                         : CHAN_W'($urandom_range(0, 31));
      follow = BYTE_W'(chan);
      if ($urandom_range(0, 1) != 0) follow = follow | FLW_NOTE;
      if ($urandom_range(0, 1) != 0) follow = follow | FLW_VOL;
      if ($urandom_range(0, 1) != 0) follow = follow | FLW_EFF;
      if (follow == 0) follow = FLW_VOL;
      push_byte(follow);
      if ((follow & FLW_NOTE) != 0) begin
        note = BYTE_W'($urandom);
        push_byte(note);
        push_byte(BYTE_W'($urandom));
        if (note[7]) push_byte(BYTE_W'($urandom));
      end
      if ((follow & FLW_VOL) != 0) push_byte(BYTE_W'($urandom));
      if ((follow & FLW_EFF) != 0) begin
        push_byte(BYTE_W'($urandom));
        push_byte(BYTE_W'($urandom));
      end
    end
    push_byte(8'h00);
  endtask

  initial begin
    int rows_planned;
    int step;
    int tail_bytes;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    set_channel_count(6'd32);

    for (int i = 0; i < 2 * HEADER_WORDS; i++) begin
      push_byte((i == 0) ? 8'h00 : (i == 1) ? 8'hff : BYTE_W'($urandom));
    end
    rows_planned = 24 + $urandom_range(0, 4);
    push_byte(BYTE_W'(rows_planned));
    push_byte(8'h00);

    foreach (SETUP_ROWS[i]) push_byte(SETUP_ROWS[i]);

    // two rows were directed; the rest come in groups of four per channel count
    for (int r = 2; r < rows_planned; r++) begin
      if ((r - 2) % 4 == 0) begin
        wait_drained();
        step = (r - 2) / 4;
        set_channel_count((step < 5) ? COUNT_STEPS[step] : CFG_W'($urandom_range(0, 63)));
      end
      send_random_row();
    end

    // the pattern is over: these must all be swallowed
    wait_drained();
    tail_bytes = bytes_sent;
    push_byte(8'h00);
    push_byte(8'hff);
    repeat (6) push_byte(BYTE_W'($urandom));
    tail_bytes = bytes_sent - tail_bytes;

    wait_drained();
    repeat (40) @(posedge clk);

    $display("covered %0d pattern bytes over %0d rows plus %0d trailing bytes, %0d cells checked",
             bytes_sent - tail_bytes, rows_planned, tail_bytes, cells_checked);
    $display("channel count written %0d times, including 0, 1, 32, 33 and 63", count_writes);
    if (mismatch_count == 0 && cells_pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

endmodule

/* tracker_pattern_decoder.f */
+incdir+rtl
rtl/tpd_pkg.sv
rtl/tpd_ctrl.sv
rtl/tpd_datapath.sv
rtl/tracker_pattern_decoder.sv
rtl/tpd_checker.sv
verif/tpd_cell_checker.sv
verif/tb_tracker_pattern_decoder.sv
